// ===== sv/noise_bandpass_percussion_voice_top_assert.svh =====
`ifndef NOISE_BANDPASS_PERCUSSION_VOICE_TOP_ASSERT_SVH
`define NOISE_BANDPASS_PERCUSSION_VOICE_TOP_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define NBPV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nbpv check failed");

// condition holds in the cycle after the trigger
`define NBPV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nbpv check failed");

`endif

// ===== sv/nbpv_pkg.sv =====
package nbpv_pkg;

    // parameter defaults
    localparam int PHASE_BITS_DEF         = 24;
    localparam int SINE_TABLE_ENTRIES_DEF = 256;
    localparam int STATE_BITS_DEF         = 24;

    // field widths
    localparam int VEL_W      = 16;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 15;
    localparam int STEP_W     = 23;
    localparam int DECAY_W    = 16;
    localparam int VOL_W      = 7;
    localparam int ENV_W      = 16;
    localparam int POLY_W     = 31;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;
    localparam int LEVEL_W    = 16;

    // fixed-point constants
    localparam logic [11:0]       DAMP_Q15      = 12'd2621;
    localparam logic [14:0]       SINE_GAIN_Q16 = 15'd19661;
    localparam logic [ENV_W-1:0]  ENV_FULL      = 16'hFFFF;
    localparam logic [ENV_W-1:0]  ENV_FLOOR     = 16'd7;
    localparam logic [6:0]        LEVEL_BIAS    = 7'd100;
    // floor(y / 25) = (y * RECIP_M) >> RECIP_SHIFT, exact for y below 2^20
    localparam logic [20:0]       RECIP_M       = 21'd1342178;
    localparam int                RECIP_SHIFT   = 25;

    // odd quarter-wave polynomial coefficients, Q30
    localparam logic [POLY_W-1:0] P_C1 = 31'd1686629713;
    localparam logic [POLY_W-1:0] P_C3 = 31'd693598668;
    localparam logic [POLY_W-1:0] P_C5 = 31'd85569304;
    localparam logic [POLY_W-1:0] P_C7 = 31'd5026995;
    localparam logic [POLY_W-1:0] P_C9 = 31'd172272;

    // register reset values
    localparam logic [COEF_W-1:0]  COEF_RST  = 15'd4096;
    localparam logic [STEP_W-1:0]  STEP_RST  = 23'd104858;
    localparam logic [DECAY_W-1:0] DECAY_RST = 16'd65500;
    localparam logic [VOL_W-1:0]   VOL_RST   = 7'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_COEF,
        CFG_PHASE_STEP,
        CFG_DECAY_MULT,
        CFG_VOLUME
    } cfg_idx_t;

    typedef enum logic {
        OPC_TICK,
        OPC_TRIGGER
    } opcode_t;

    typedef enum logic [3:0] {
        OP_DAMP,
        OP_BAND,
        OP_LOW,
        OP_TSQ,
        OP_HORNER,
        OP_TP,
        OP_SENV,
        OP_SGAIN,
        OP_VOL,
        OP_RECIP,
        OP_SUMENV,
        OP_LEVEL,
        OP_DECAY
    } mul_op_t;

    typedef enum logic [1:0] {
        COEF_C7,
        COEF_C5,
        COEF_C3,
        COEF_C1
    } coef_sel_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_M_DAMP,  ST_W_DAMP,
        ST_M_BAND,  ST_W_BAND,
        ST_M_LOW,   ST_W_LOW,
        ST_M_TSQ,   ST_W_TSQ,
        ST_M_H7,    ST_W_H7,
        ST_M_H5,    ST_W_H5,
        ST_M_H3,    ST_W_H3,
        ST_M_H1,    ST_W_H1,
        ST_M_TP,    ST_W_TP,
        ST_M_SENV,  ST_W_SENV,
        ST_M_SGAIN, ST_W_SGAIN,
        ST_M_VOL,   ST_W_VOL,
        ST_M_RECIP, ST_W_RECIP,
        ST_M_SUM,   ST_W_SUM,
        ST_M_LEVEL, ST_W_LEVEL,
        ST_M_DECAY, ST_W_DECAY,
        ST_EMIT,
        ST_EMIT_ZERO
    } nbpv_state_t;

    typedef struct packed {
        logic      load;
        logic      trigger;
        logic      mul_en;
        logic      wb_en;
        mul_op_t   op;
        coef_sel_t coef;
        logic      emit;
        logic      emit_zero;
    } nbpv_cmd_t;

    typedef struct packed {
        logic voice_on;
        logic out_busy;
    } nbpv_status_t;

endpackage

// ===== sv/nbpv_ctrl.sv =====
module nbpv_ctrl
    import nbpv_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,
    input  nbpv_status_t status,
    output nbpv_cmd_t    cmd
);

    nbpv_state_t state_reg;
    nbpv_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (opcode_t'(s_tuser) == OPC_TRIGGER) begin
                        state_next = ST_EMIT_ZERO;
                    end else if (status.voice_on) begin
                        state_next = ST_M_DAMP;
                    end else begin
                        state_next = ST_EMIT_ZERO;
                    end
                end
            end
            ST_M_DAMP:  state_next = ST_W_DAMP;
            ST_W_DAMP:  state_next = ST_M_BAND;
            ST_M_BAND:  state_next = ST_W_BAND;
            ST_W_BAND:  state_next = ST_M_LOW;
            ST_M_LOW:   state_next = ST_W_LOW;
            ST_W_LOW:   state_next = ST_M_TSQ;
            ST_M_TSQ:   state_next = ST_W_TSQ;
            ST_W_TSQ:   state_next = ST_M_H7;
            ST_M_H7:    state_next = ST_W_H7;
            ST_W_H7:    state_next = ST_M_H5;
            ST_M_H5:    state_next = ST_W_H5;
            ST_W_H5:    state_next = ST_M_H3;
            ST_M_H3:    state_next = ST_W_H3;
            ST_W_H3:    state_next = ST_M_H1;
            ST_M_H1:    state_next = ST_W_H1;
            ST_W_H1:    state_next = ST_M_TP;
            ST_M_TP:    state_next = ST_W_TP;
            ST_W_TP:    state_next = ST_M_SENV;
            ST_M_SENV:  state_next = ST_W_SENV;
            ST_W_SENV:  state_next = ST_M_SGAIN;
            ST_M_SGAIN: state_next = ST_W_SGAIN;
            ST_W_SGAIN: state_next = ST_M_VOL;
            ST_M_VOL:   state_next = ST_W_VOL;
            ST_W_VOL:   state_next = ST_M_RECIP;
            ST_M_RECIP: state_next = ST_W_RECIP;
            ST_W_RECIP: state_next = ST_M_SUM;
            ST_M_SUM:   state_next = ST_W_SUM;
            ST_W_SUM:   state_next = ST_M_LEVEL;
            ST_M_LEVEL: state_next = ST_W_LEVEL;
            ST_W_LEVEL: state_next = ST_M_DECAY;
            ST_M_DECAY: state_next = ST_W_DECAY;
            ST_W_DECAY: state_next = ST_EMIT;
            ST_EMIT, ST_EMIT_ZERO: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // command decode
    always_comb begin
        cmd      = '0;
        cmd.op   = OP_DAMP;
        cmd.coef = COEF_C7;
        s_tready = 1'b0;

        case (state_reg)
            ST_M_DAMP,  ST_W_DAMP:  cmd.op = OP_DAMP;
            ST_M_BAND,  ST_W_BAND:  cmd.op = OP_BAND;
            ST_M_LOW,   ST_W_LOW:   cmd.op = OP_LOW;
            ST_M_TSQ,   ST_W_TSQ:   cmd.op = OP_TSQ;
            ST_M_H7,    ST_W_H7: begin
                cmd.op   = OP_HORNER;
                cmd.coef = COEF_C7;
            end
            ST_M_H5,    ST_W_H5: begin
                cmd.op   = OP_HORNER;
                cmd.coef = COEF_C5;
            end
            ST_M_H3,    ST_W_H3: begin
                cmd.op   = OP_HORNER;
                cmd.coef = COEF_C3;
            end
            ST_M_H1,    ST_W_H1: begin
                cmd.op   = OP_HORNER;
                cmd.coef = COEF_C1;
            end
            ST_M_TP,    ST_W_TP:    cmd.op = OP_TP;
            ST_M_SENV,  ST_W_SENV:  cmd.op = OP_SENV;
            ST_M_SGAIN, ST_W_SGAIN: cmd.op = OP_SGAIN;
            ST_M_VOL,   ST_W_VOL:   cmd.op = OP_VOL;
            ST_M_RECIP, ST_W_RECIP: cmd.op = OP_RECIP;
            ST_M_SUM,   ST_W_SUM:   cmd.op = OP_SUMENV;
            ST_M_LEVEL, ST_W_LEVEL: cmd.op = OP_LEVEL;
            ST_M_DECAY, ST_W_DECAY: cmd.op = OP_DECAY;
            default:                cmd.op = OP_DAMP;
        endcase

        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load    = s_tvalid;
                cmd.trigger = s_tvalid && (opcode_t'(s_tuser) == OPC_TRIGGER);
            end
            ST_M_DAMP, ST_M_BAND, ST_M_LOW, ST_M_TSQ, ST_M_H7, ST_M_H5, ST_M_H3,
            ST_M_H1, ST_M_TP, ST_M_SENV, ST_M_SGAIN, ST_M_VOL, ST_M_RECIP,
            ST_M_SUM, ST_M_LEVEL, ST_M_DECAY: begin
                cmd.mul_en = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = !status.out_busy;
            end
            ST_EMIT_ZERO: begin
                cmd.emit      = !status.out_busy;
                cmd.emit_zero = 1'b1;
            end
            default: begin
                cmd.wb_en = 1'b1;
            end
        endcase
    end

endmodule

// ===== sv/nbpv_datapath.sv =====
`include "noise_bandpass_percussion_voice_top_assert.svh"

module nbpv_datapath
    import nbpv_pkg::*;
#(
    parameter int PHASE_BITS         = PHASE_BITS_DEF,
    parameter int SINE_TABLE_ENTRIES = SINE_TABLE_ENTRIES_DEF,
    parameter int STATE_BITS         = STATE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  nbpv_cmd_t             cmd,
    output nbpv_status_t          status,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int SB  = STATE_BITS;
    localparam int HW  = SB + 1;
    localparam int AW  = (HW > 32) ? HW : 32;
    localparam int BW  = 32;
    localparam int PW  = AW + BW;
    localparam int TB  = $clog2(SINE_TABLE_ENTRIES + 1) - 1;
    localparam int QB  = TB - 2;
    localparam int PSW = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

    localparam logic signed [PW-1:0] HALF14 = PW'(8192);
    localparam logic signed [PW-1:0] HALF15 = PW'(16384);
    localparam logic signed [PW-1:0] HALF16 = PW'(32768);
    localparam logic signed [PW-1:0] SB_MAX = (PW'(1) <<< (SB - 1)) - PW'(1);
    localparam logic signed [PW-1:0] SB_MIN = -SB_MAX - PW'(1);
    localparam logic signed [PW-1:0] S16_MAX = PW'(32767);
    localparam logic signed [PW-1:0] S16_MIN = -PW'(32768);
    localparam logic [POLY_W-1:0]    T_ONE  = 31'h4000_0000;

    // configuration
    logic [COEF_W-1:0]  coef_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [DECAY_W-1:0] decay_reg;
    logic [VOL_W-1:0]   volume_reg;

    // voice state
    logic [VEL_W-1:0]             vel_reg;
    logic signed [SAMPLE_W-1:0]   noise_reg;
    logic signed [SB-1:0]         band_reg;
    logic signed [SB-1:0]         low_reg;
    logic signed [HW-1:0]         high_reg;
    logic [PHASE_BITS-1:0]        phase_reg;
    logic [ENV_W-1:0]             env_reg;
    logic                         voice_on_reg;

    // work registers
    logic [POLY_W-1:0]            t2_reg;
    logic [POLY_W-1:0]            poly_reg;
    logic signed [SAMPLE_W-1:0]   sine_reg;
    logic signed [AW-1:0]         tmp_reg;
    logic [LEVEL_W-1:0]           level_reg;
    logic signed [SAMPLE_W-1:0]   sample_reg;
    logic signed [PW-1:0]         prod_reg;

    // output register
    logic                         out_valid_reg;
    logic signed [SAMPLE_W-1:0]   out_sample_reg;
    logic                         out_active_reg;

    // combinational
    logic [TB-1:0]                k_idx;
    logic [1:0]                   quad;
    logic [POLY_W-1:0]            t_base;
    logic [POLY_W-1:0]            t_arg;
    logic signed [HW-1:0]         sum_w;
    logic signed [AW-1:0]         a_op;
    logic signed [BW-1:0]         b_op;
    logic [POLY_W-1:0]            coef_val;
    logic signed [PW-1:0]         rnd14;
    logic signed [PW-1:0]         rnd15;
    logic signed [PW-1:0]         rnd16;
    logic signed [PW-1:0]         high_w;
    logic signed [PW-1:0]         band_w;
    logic signed [PW-1:0]         low_w;
    logic signed [PW-1:0]         vol_w;
    logic [31:0]                  tp_sum;
    logic [16:0]                  tp_mag;
    logic [SAMPLE_W-1:0]          sine_mag;
    logic [PSW-1:0]               phase_sum;
    logic [ENV_W-1:0]             env_next;

    function automatic logic signed [SB-1:0] sat_state(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] c;
        begin
            if (v > SB_MAX) begin
                c = SB_MAX;
            end else if (v < SB_MIN) begin
                c = SB_MIN;
            end else begin
                c = v;
            end
            return c[SB-1:0];
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] c;
        begin
            if (v > S16_MAX) begin
                c = S16_MAX;
            end else if (v < S16_MIN) begin
                c = S16_MIN;
            end else begin
                c = v;
            end
            return c[SAMPLE_W-1:0];
        end
    endfunction

    // sine argument from the top phase bits, folded into one quarter wave
    assign k_idx  = phase_reg[PHASE_BITS-1 -: TB];
    assign quad   = k_idx[TB-1:QB];
    assign t_base = POLY_W'(k_idx[QB-1:0]) << (30 - QB);
    assign t_arg  = quad[0] ? (T_ONE - t_base) : t_base;

    assign sum_w = HW'(band_reg) + HW'(sine_reg);

    always_comb begin
        case (cmd.coef)
            COEF_C7: coef_val = P_C7;
            COEF_C5: coef_val = P_C5;
            COEF_C3: coef_val = P_C3;
            COEF_C1: coef_val = P_C1;
            default: coef_val = P_C1;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        case (cmd.op)
            OP_DAMP: begin
                a_op = AW'(band_reg);
                b_op = $signed(BW'(DAMP_Q15));
            end
            OP_BAND: begin
                a_op = AW'(high_reg);
                b_op = $signed(BW'(coef_reg));
            end
            OP_LOW: begin
                a_op = AW'(band_reg);
                b_op = $signed(BW'(coef_reg));
            end
            OP_TSQ: begin
                a_op = AW'($signed({1'b0, t_arg}));
                b_op = $signed(BW'(t_arg));
            end
            OP_HORNER: begin
                a_op = AW'($signed({1'b0, t2_reg}));
                b_op = $signed(BW'(poly_reg));
            end
            OP_TP: begin
                a_op = AW'($signed({1'b0, t_arg}));
                b_op = $signed(BW'(poly_reg));
            end
            OP_SENV: begin
                a_op = AW'(sine_reg);
                b_op = $signed(BW'(env_reg));
            end
            OP_SGAIN: begin
                a_op = tmp_reg;
                b_op = $signed(BW'(SINE_GAIN_Q16));
            end
            OP_VOL: begin
                a_op = AW'($signed({1'b0, volume_reg}));
                b_op = $signed(BW'(vel_reg));
            end
            OP_RECIP: begin
                a_op = tmp_reg;
                b_op = $signed(BW'(RECIP_M));
            end
            OP_SUMENV: begin
                a_op = AW'(sum_w);
                b_op = $signed(BW'(env_reg));
            end
            OP_LEVEL: begin
                a_op = tmp_reg;
                b_op = $signed(BW'(level_reg));
            end
            OP_DECAY: begin
                a_op = AW'($signed({1'b0, env_reg}));
                b_op = $signed(BW'(decay_reg));
            end
            default: begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    // write-back arithmetic on the registered product
    assign rnd14  = (prod_reg + HALF14) >>> 14;
    assign rnd15  = (prod_reg + HALF15) >>> 15;
    assign rnd16  = (prod_reg + HALF16) >>> 16;
    assign high_w = PW'(noise_reg) - PW'(low_reg) - rnd15;
    assign band_w = PW'(band_reg) + rnd14;
    assign low_w  = PW'(low_reg) + rnd14;
    assign vol_w  = (prod_reg + PW'(LEVEL_BIAS)) >>> 3;

    assign tp_sum   = prod_reg[61:30] + 32'd16384;
    assign tp_mag   = tp_sum[31:15];
    assign sine_mag = (tp_mag > 17'd32767) ? 16'd32767 : SAMPLE_W'(tp_mag);

    assign phase_sum = PSW'(phase_reg) + PSW'(step_reg);
    assign env_next  = prod_reg[31:16];

    // configuration, voice activity and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg      <= COEF_RST;
            step_reg      <= STEP_RST;
            decay_reg     <= DECAY_RST;
            volume_reg    <= VOL_RST;
            voice_on_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FILTER_COEF: coef_reg   <= cfg_data[COEF_W-1:0];
                    CFG_PHASE_STEP:  step_reg   <= cfg_data[STEP_W-1:0];
                    CFG_DECAY_MULT:  decay_reg  <= cfg_data[DECAY_W-1:0];
                    CFG_VOLUME:      volume_reg <= cfg_data[VOL_W-1:0];
                    default:         volume_reg <= volume_reg;
                endcase
            end

            if (cmd.trigger) begin
                voice_on_reg <= 1'b1;
            end else if (cmd.wb_en && (cmd.op == OP_DECAY)) begin
                voice_on_reg <= (env_next >= ENV_FLOOR);
            end

            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            noise_reg <= $signed(s_tdata[S_TDATA_W-1:VEL_W]);
        end

        if (cmd.trigger) begin
            vel_reg   <= s_tdata[VEL_W-1:0];
            band_reg  <= '0;
            low_reg   <= '0;
            phase_reg <= '0;
            env_reg   <= ENV_FULL;
        end

        if (cmd.mul_en) begin
            prod_reg <= a_op * b_op;
        end

        if (cmd.wb_en) begin
            case (cmd.op)
                OP_DAMP:   high_reg  <= high_w[HW-1:0];
                OP_BAND:   band_reg  <= sat_state(band_w);
                OP_LOW:    low_reg   <= sat_state(low_w);
                OP_TSQ: begin
                    t2_reg   <= prod_reg[60:30];
                    poly_reg <= P_C9;
                end
                OP_HORNER: poly_reg  <= coef_val - prod_reg[60:30];
                OP_TP: begin
                    sine_reg  <= quad[1] ? -$signed(sine_mag) : $signed(sine_mag);
                    phase_reg <= phase_sum[PHASE_BITS-1:0];
                end
                OP_SENV:   tmp_reg   <= rnd16[AW-1:0];
                OP_SGAIN:  sine_reg  <= rnd16[SAMPLE_W-1:0];
                OP_VOL:    tmp_reg   <= vol_w[AW-1:0];
                OP_RECIP:  level_reg <= prod_reg[RECIP_SHIFT +: LEVEL_W];
                OP_SUMENV: tmp_reg   <= rnd16[AW-1:0];
                OP_LEVEL:  sample_reg <= sat_sample(rnd16);
                OP_DECAY:  env_reg   <= env_next;
                default:   tmp_reg   <= tmp_reg;
            endcase
        end

        if (cmd.emit) begin
            out_sample_reg <= cmd.emit_zero ? '0 : sample_reg;
            out_active_reg <= voice_on_reg;
        end
    end

    assign status.voice_on = voice_on_reg;
    assign status.out_busy = out_valid_reg && !m_tready;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_TDATA_W - SAMPLE_W - 1){1'b0}}, out_active_reg, out_sample_reg};

    `NBPV_ASSERT_NOW(a_one_phase, cmd.mul_en, !cmd.wb_en)
    `NBPV_ASSERT_NOW(a_emit_room, cmd.emit, !(out_valid_reg && !m_tready))
    `NBPV_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_reg)
    `NBPV_ASSERT_NEXT(a_trigger_on, cmd.trigger, voice_on_reg && (env_reg == ENV_FULL))
    `NBPV_ASSERT_NEXT(a_decay_floor, cmd.wb_en && (cmd.op == OP_DECAY), voice_on_reg == (env_reg >= ENV_FLOOR))

endmodule

// ===== sv/noise_bandpass_percussion_voice_top.sv =====
// a trigger or silent tick goes from ST_IDLE straight to ST_EMIT_ZERO; a sounding tick runs
// through one shared multiplier doing 16 products, each a multiply and a write-back state,
// then ST_EMIT, which holds while the previous output word is not taken; no new word is taken
// before its word is registered, but one is taken while that result still waits in the output register
// reset: aresetn synchronous active low; voice goes inactive, registers take their defaults,
// output empties; no clearing pass, first word may be accepted right after reset
module noise_bandpass_percussion_voice_top
    import nbpv_pkg::*;
#(
    parameter int PHASE_BITS         = PHASE_BITS_DEF,          // sine phase accumulator width
    parameter int SINE_TABLE_ENTRIES = SINE_TABLE_ENTRIES_DEF,  // angular resolution of the sine
    parameter int STATE_BITS         = STATE_BITS_DEF           // saturating filter state width
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // velocity [15:0], noise_sample [31:16]
    input  logic                  s_tuser,   // opcode: tick or trigger

    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // sample_out [15:0], active [16], zero [23:17]

    // register write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index, // filter_coef, phase_step, decay_mult, volume
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // command and status between sequencer and datapath
    nbpv_cmd_t    cmd;
    nbpv_status_t status;

    // sequencer: steps the filter, sine polynomial, level and decay products
    nbpv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: voice state, shared multiplier, registers, output word register
    nbpv_datapath #(
        .PHASE_BITS         (PHASE_BITS),
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
        .STATE_BITS         (STATE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== tb/noise_bandpass_percussion_voice_top_tb.sv =====
`timescale 1ns / 100ps

module noise_bandpass_percussion_voice_top_tb
    import nbpv_pkg::*;
();

    // sine table index width; the default entry count is a power of two
    localparam int TBL_BITS    = $clog2(SINE_TABLE_ENTRIES_DEF);
    localparam int QUAD_BITS   = TBL_BITS - 2;
    localparam int MAX_REPORTS = 10;
    localparam int SEGMENTS    = 6;
    localparam int SEG_WORDS   = 100;
    // quiet tail after the last word that catches stray words
    localparam int TAIL_CYCLES = 68;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                active;
    } voice_word_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    // one row of the directed table: an input word or a register write
    typedef struct packed {
        row_kind_t             kind;
        opcode_t               op;
        logic [VEL_W-1:0]      vel;
        logic [SAMPLE_W-1:0]   noise;
        cfg_idx_t              idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  typed;      // expected word given in the row
        logic [SAMPLE_W-1:0]   exp_sample;
        logic                  exp_active;
    } stim_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // register copies, at their reset values
    logic [COEF_W-1:0]  coef_q  = COEF_RST;
    logic [STEP_W-1:0]  step_q  = STEP_RST;
    logic [DECAY_W-1:0] decay_q = DECAY_RST;
    logic [VOL_W-1:0]   vol_q   = VOL_RST;

    // voice state copy, all zero after reset
    logic [VEL_W-1:0]          voice_vel_q   = '0;
    logic [PHASE_BITS_DEF-1:0] voice_phase_q = '0;
    logic [ENV_W-1:0]          voice_env_q   = '0;
    logic                      voice_on_q    = 1'b0;
    longint                    band_q        = 0;
    longint                    low_q         = 0;

    voice_word_t expected_words[$];
    int unsigned mismatches    = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    always #4 aclk = ~aclk;

    noise_bandpass_percussion_voice_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // round half up: add half an lsb, then floor
    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_bits(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // sin(pi/2 * t), t in Q30, odd polynomial by horner, result Q1.15
    function automatic longint quarter_wave(longint unsigned t);
        longint unsigned t2;
        longint unsigned p;
        longint unsigned r;
        t2 = (t * t) >> 30;
        p  = 64'(P_C9);
        p  = 64'(P_C7) - ((t2 * p) >> 30);
        p  = 64'(P_C5) - ((t2 * p) >> 30);
        p  = 64'(P_C3) - ((t2 * p) >> 30);
        p  = 64'(P_C1) - ((t2 * p) >> 30);
        r  = (t * p) >> 30;
        r  = (r + 64'd16384) >> 15;
        return (r > 64'd32767) ? longint'(32767) : longint'(r);
    endfunction

    // full wave from the quarter wave: odd quadrants mirror, upper half negates
    function automatic longint sine_lookup(logic [TBL_BITS-1:0] k);
        longint unsigned t;
        longint          s;
        t = 64'(k[QUAD_BITS-1:0]);
        t = t << (30 - QUAD_BITS);
        if (k[QUAD_BITS]) t = (64'd1 << 30) - t;
        s = quarter_wave(t);
        return k[QUAD_BITS+1] ? -s : s;
    endfunction

    // advances the voice copy by one word and returns the word it gives
    function automatic voice_word_t voice_output(opcode_t op, logic [VEL_W-1:0] vel,
                                                 logic signed [SAMPLE_W-1:0] noise);
        longint      f;
        longint      env;
        longint      damp;
        longint      gain;
        longint      lvl;
        longint      hp;
        longint      sn;
        longint      mix;
        longint      clip;
        voice_word_t wd;
        damp      = longint'(DAMP_Q15);
        gain      = longint'(SINE_GAIN_Q16);
        f         = longint'(coef_q);
        env       = longint'(voice_env_q);
        wd.sample = '0;
        if (op == OPC_TRIGGER) begin
            voice_vel_q   = vel;
            voice_on_q    = 1'b1;
            voice_phase_q = '0;
            voice_env_q   = ENV_FULL;
            band_q        = 0;
            low_q         = 0;
        end else if (voice_on_q) begin
            // state-variable bandpass, saturating states
            hp     = longint'(noise) - low_q - round_shift(damp * band_q, 15);
            band_q = clamp_bits(band_q + round_shift(f * hp, 14), STATE_BITS_DEF);
            low_q  = clamp_bits(low_q + round_shift(f * band_q, 14), STATE_BITS_DEF);
            // sine body from the phase before the step
            sn = sine_lookup(voice_phase_q[PHASE_BITS_DEF-1 -: TBL_BITS]);
            sn = round_shift(round_shift(sn * env, 16) * gain, 16);
            voice_phase_q = voice_phase_q + PHASE_BITS_DEF'(step_q);
            lvl  = longint'(vol_q);
            lvl  = (lvl * longint'(voice_vel_q) + 100) / 200;
            mix  = band_q + sn;
            clip = clamp_bits(round_shift(round_shift(mix * env, 16) * lvl, 16), SAMPLE_W);
            wd.sample = clip[SAMPLE_W-1:0];
            // truncating decay, voice stops under the floor
            voice_env_q = ENV_W'((env * longint'(decay_q)) >> 16);
            if (voice_env_q < ENV_FLOOR) voice_on_q = 1'b0;
        end
        wd.active = voice_on_q;
        return wd;
    endfunction

    function automatic stim_row_t item_row(opcode_t op, logic [VEL_W-1:0] vel,
                                           logic [SAMPLE_W-1:0] noise, logic typed,
                                           logic [SAMPLE_W-1:0] s, logic a);
        stim_row_t r;
        r            = '0;
        r.kind       = ROW_ITEM;
        r.op         = op;
        r.vel        = vel;
        r.noise      = noise;
        r.typed      = typed;
        r.exp_sample = s;
        r.exp_active = a;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    // offer one input word, return the predicted output once it is taken
    task automatic send_word(input opcode_t op, input logic [VEL_W-1:0] vel,
                             input logic [SAMPLE_W-1:0] noise, output voice_word_t pred);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {noise, vel};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = voice_output(op, vel, $signed(noise));
    endtask

    // hold the sender until every expected word has come back
    task automatic drain_words;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_words.size() != 0);
    endtask

    // register write, only called with the block idle
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FILTER_COEF: coef_q  = data[COEF_W-1:0];
            CFG_PHASE_STEP:  step_q  = data[STEP_W-1:0];
            CFG_DECAY_MULT:  decay_q = data[DECAY_W-1:0];
            CFG_VOLUME:      vol_q   = data[VOL_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // result side: compare each word taken with the oldest expectation
    always @(posedge aclk) begin : result_check
        voice_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: sample %0d active %0b",
                             $signed(m_tdata[SAMPLE_W-1:0]), m_tdata[SAMPLE_W]);
            end else begin
                want = expected_words.pop_front();
                if (m_tdata[SAMPLE_W-1:0] !== want.sample ||
                    m_tdata[SAMPLE_W] !== want.active) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: expected sample %0d active %0b, ",
                                  "got sample %0d active %0b"},
                                 $signed(want.sample), want.active,
                                 $signed(m_tdata[SAMPLE_W-1:0]), m_tdata[SAMPLE_W]);
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        stim_row_t             rows[$];
        stim_row_t             r;
        voice_word_t           wd;
        opcode_t               op;
        logic [VEL_W-1:0]      vel;
        logic [SAMPLE_W-1:0]   noise;
        logic [CFG_DATA_W-1:0] seg_cfg[4];
        int                    run_left;

        // directed table: typed words where obvious, the rest predicted
        rows.push_back(item_row(OPC_TICK,    16'hFFFF, 16'h7FFF, 1'b1, 16'd0, 1'b0));
        rows.push_back(item_row(OPC_TICK,    16'h0000, 16'h8000, 1'b1, 16'd0, 1'b0));
        rows.push_back(item_row(OPC_TRIGGER, 16'hFFFF, 16'h8000, 1'b1, 16'd0, 1'b1));
        rows.push_back(item_row(OPC_TICK,    16'h0000, 16'h7FFF, 1'b0, 16'd0, 1'b0));
        rows.push_back(item_row(OPC_TICK,    16'h0000, 16'h8000, 1'b0, 16'd0, 1'b0));
        rows.push_back(item_row(OPC_TICK,    16'hFFFF, 16'h0000, 1'b0, 16'd0, 1'b0));
        // zero velocity gives zero level, voice still sounds
        rows.push_back(item_row(OPC_TRIGGER, 16'h0000, 16'h7FFF, 1'b1, 16'd0, 1'b1));
        rows.push_back(item_row(OPC_TICK,    16'h0000, 16'h7FFF, 1'b1, 16'd0, 1'b1));
        // volume above one hundred is taken as given
        rows.push_back(cfg_row(CFG_VOLUME, 23'd127));
        rows.push_back(item_row(OPC_TRIGGER, 16'hFFFF, 16'h0000, 1'b1, 16'd0, 1'b1));
        rows.push_back(item_row(OPC_TICK,    16'h0000, 16'h7FFF, 1'b0, 16'd0, 1'b0));
        rows.push_back(item_row(OPC_TICK,    16'h0000, 16'h7FFF, 1'b0, 16'd0, 1'b0));
        // zero decay: one sample, then silent
        rows.push_back(cfg_row(CFG_DECAY_MULT, 23'd0));
        rows.push_back(item_row(OPC_TICK,    16'h0000, 16'h8000, 1'b0, 16'd0, 1'b0));
        rows.push_back(item_row(OPC_TICK,    16'hFFFF, 16'h7FFF, 1'b1, 16'd0, 1'b0));
        rows.push_back(item_row(OPC_TRIGGER, 16'h0001, 16'h0000, 1'b1, 16'd0, 1'b1));
        rows.push_back(item_row(OPC_TICK,    16'h0000, 16'h8000, 1'b0, 16'd0, 1'b0));
        // top of every register range
        rows.push_back(cfg_row(CFG_DECAY_MULT, 23'd65535));
        rows.push_back(cfg_row(CFG_FILTER_COEF, 23'd32767));
        rows.push_back(cfg_row(CFG_PHASE_STEP, 23'd8388607));
        rows.push_back(item_row(OPC_TRIGGER, 16'h8000, 16'h0000, 1'b1, 16'd0, 1'b1));
        rows.push_back(item_row(OPC_TICK,    16'h0000, 16'h7FFF, 1'b0, 16'd0, 1'b0));
        rows.push_back(item_row(OPC_TICK,    16'h0000, 16'h8000, 1'b0, 16'd0, 1'b0));
        rows.push_back(item_row(OPC_TICK,    16'h0000, 16'h7FFF, 1'b0, 16'd0, 1'b0));
        rows.push_back(item_row(OPC_TICK,    16'h0000, 16'h8000, 1'b0, 16'd0, 1'b0));
        // zero volume silences a sounding voice
        rows.push_back(cfg_row(CFG_VOLUME, 23'd0));
        rows.push_back(item_row(OPC_TICK,    16'h0000, 16'h7FFF, 1'b1, 16'd0, 1'b1));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 16;
        recv_idle_pct = 76;
        foreach (rows[i]) begin
            r = rows[i];
            if (r.kind == ROW_CFG) begin
                drain_words();
                write_reg(r.idx, r.data);
            end else begin
                send_word(r.op, r.vel, r.noise, wd);
                if (r.typed) begin
                    wd.sample = r.exp_sample;
                    wd.active = r.exp_active;
                end
                expected_words.push_back(wd);
            end
        end

        // random part: one register setting per segment, idling changes every two
        run_left = 0;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain_words();
            case (seg / 2)
                0: begin send_idle_pct = 16; recv_idle_pct = 76; end
                1: begin send_idle_pct = 76; recv_idle_pct = 16; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (seg)
                0: seg_cfg = '{23'd32767, 23'd8388607, 23'd60000, 23'd127};
                1: seg_cfg = '{23'd0, 23'd0, 23'd0, 23'd0};
                2: seg_cfg = '{CFG_DATA_W'($urandom_range(0, 32767)),
                               CFG_DATA_W'($urandom_range(0, 8388607)),
                               CFG_DATA_W'($urandom_range(40000, 65535)),
                               CFG_DATA_W'($urandom_range(0, 127))};
                // raw data, bits above each register width must be dropped
                3: seg_cfg = '{CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                               CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom())};
                4: seg_cfg = '{23'd8000, 23'd200000, 23'd50000, 23'd100};
                default: seg_cfg = '{23'd4096, 23'd104858, 23'd62000, 23'd100};
            endcase
            for (int i = 0; i < 4; i++) write_reg(cfg_idx_t'(i), seg_cfg[i]);

            for (int n = 0; n < SEG_WORDS; n++) begin
                // mostly a trigger followed by a run of ticks, some stray opcodes
                if (run_left == 0) begin
                    op       = OPC_TRIGGER;
                    run_left = int'($urandom_range(0, 40));
                end else begin
                    op = OPC_TICK;
                    run_left--;
                end
                if ($urandom_range(0, 19) == 0) op = opcode_t'($urandom_range(0, 1));
                vel = VEL_W'($urandom());
                if ($urandom_range(0, 6) == 0)
                    noise = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                else
                    noise = SAMPLE_W'($urandom());
                if ($urandom_range(0, 63) == 0) drain_words();
                send_word(op, vel, noise, wd);
                expected_words.push_back(wd);
            end
        end

        drain_words();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
